### sv/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types and constants for the battery level monitor: payload structs,
// configuration set, register indexes, event codes, reset values and timing constants.
// ----------------------------------------------------------------------------
package blm_pkg;

    // Field widths
    localparam int MV_W      = 13;
    localparam int PCT_W     = 7;
    localparam int EV_W      = 3;
    localparam int LVL_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int TICK8_W   = 8;
    localparam int FULL_W    = 10;
    localparam int RECOV_W   = 5;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EV_W-1:0] EV_LOW_WARN    = 3'd1;
    localparam logic [EV_W-1:0] EV_FULL        = 3'd2;
    localparam logic [EV_W-1:0] EV_SHUTDOWN    = 3'd3;
    localparam logic [EV_W-1:0] EV_LOW_CLEARED = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WARN_MV       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CANCEL_MV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_MV       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECHARGE_MV       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_DETECT_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_TICKS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_DETECT_TICKS = 3'd7;

    // Configuration reset values
    localparam logic [MV_W-1:0]    RST_LOW_WARN_MV       = 13'd3550;
    localparam logic [MV_W-1:0]    RST_LOW_CANCEL_MV     = 13'd3750;
    localparam logic [MV_W-1:0]    RST_SHUTDOWN_MV       = 13'd3400;
    localparam logic [MV_W-1:0]    RST_FULL_MV           = 13'd4050;
    localparam logic [MV_W-1:0]    RST_RECHARGE_MV       = 13'd4000;
    localparam logic [TICK8_W-1:0] RST_LOW_DETECT_TICKS  = 8'd30;
    localparam logic [TICK8_W-1:0] RST_SHUTDOWN_TICKS    = 8'd20;
    localparam logic [FULL_W-1:0]  RST_FULL_DETECT_TICKS = 10'd180;

    // Fixed timing constants
    localparam logic [TICK8_W-1:0] REPEAT_WARN_TICKS = 8'd90;
    localparam logic [RECOV_W-1:0] RECOVER_TICKS     = 5'd15;
    localparam logic [FULL_W-1:0]  FULL_DROP_TICKS   = 10'd600;
    localparam logic [PCT_W-1:0]   PCT_FULL          = 7'd100;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic             charger_on;
        logic [PCT_W-1:0] charge_percent;
    } t_in_item;

    typedef struct packed {
        logic [EV_W-1:0]         event_code;
        logic signed [LVL_W-1:0] level_report;
        logic                    low_active;
    } t_out_item;

    typedef struct packed {
        logic [MV_W-1:0]    low_warn_mv;
        logic [MV_W-1:0]    low_cancel_mv;
        logic [MV_W-1:0]    shutdown_mv;
        logic [MV_W-1:0]    full_mv;
        logic [MV_W-1:0]    recharge_mv;
        logic [TICK8_W-1:0] low_detect_ticks;
        logic [TICK8_W-1:0] shutdown_ticks;
        logic [FULL_W-1:0]  full_detect_ticks;
    } t_cfg;

endpackage

### sv/blm_stream_if.sv
// ----------------------------------------------------------------------------
// blm_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface blm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/blm_cfg_regs.sv
// ----------------------------------------------------------------------------
// blm_cfg_regs
// Threshold and debounce registers, written through a plain indexed port.
// ----------------------------------------------------------------------------
module blm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [blm_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    output blm_pkg::t_cfg                  o_cfg
);

    blm_pkg::t_cfg r_cfg;

    // Load defaults on reset, update one register per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_warn_mv       <= blm_pkg::RST_LOW_WARN_MV;
            r_cfg.low_cancel_mv     <= blm_pkg::RST_LOW_CANCEL_MV;
            r_cfg.shutdown_mv       <= blm_pkg::RST_SHUTDOWN_MV;
            r_cfg.full_mv           <= blm_pkg::RST_FULL_MV;
            r_cfg.recharge_mv       <= blm_pkg::RST_RECHARGE_MV;
            r_cfg.low_detect_ticks  <= blm_pkg::RST_LOW_DETECT_TICKS;
            r_cfg.shutdown_ticks    <= blm_pkg::RST_SHUTDOWN_TICKS;
            r_cfg.full_detect_ticks <= blm_pkg::RST_FULL_DETECT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                blm_pkg::REG_LOW_WARN_MV: begin
                    r_cfg.low_warn_mv <= i_cfg_wdata[blm_pkg::MV_W-1:0];
                end
                blm_pkg::REG_LOW_CANCEL_MV: begin
                    r_cfg.low_cancel_mv <= i_cfg_wdata[blm_pkg::MV_W-1:0];
                end
                blm_pkg::REG_SHUTDOWN_MV: begin
                    r_cfg.shutdown_mv <= i_cfg_wdata[blm_pkg::MV_W-1:0];
                end
                blm_pkg::REG_FULL_MV: begin
                    r_cfg.full_mv <= i_cfg_wdata[blm_pkg::MV_W-1:0];
                end
                blm_pkg::REG_RECHARGE_MV: begin
                    r_cfg.recharge_mv <= i_cfg_wdata[blm_pkg::MV_W-1:0];
                end
                blm_pkg::REG_LOW_DETECT_TICKS: begin
                    r_cfg.low_detect_ticks <= i_cfg_wdata[blm_pkg::TICK8_W-1:0];
                end
                blm_pkg::REG_SHUTDOWN_TICKS: begin
                    r_cfg.shutdown_ticks <= i_cfg_wdata[blm_pkg::TICK8_W-1:0];
                end
                blm_pkg::REG_FULL_DETECT_TICKS: begin
                    r_cfg.full_detect_ticks <= i_cfg_wdata[blm_pkg::FULL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/blm_core.sv
// ----------------------------------------------------------------------------
// blm_core
// Monitor state and per-tick decision logic. Computes the result for the
// item presented and commits the new state when the item advances.
// ----------------------------------------------------------------------------
module blm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  blm_pkg::t_in_item  i_item,
    input  blm_pkg::t_cfg      i_cfg,
    output blm_pkg::t_out_item o_result
);

    localparam logic [blm_pkg::TICK8_W-1:0] TICK8_MAX = '1;
    localparam logic [blm_pkg::FULL_W-1:0]  FULL_MAX  = '1;
    localparam logic [blm_pkg::RECOV_W-1:0] RECOV_MAX = '1;

    logic                          r_low_mode,        n_low_mode;
    logic                          r_charging_seen,   n_charging_seen;
    logic                          r_full_seen,       n_full_seen;
    logic [blm_pkg::TICK8_W-1:0]   r_low_counter,     n_low_counter;
    logic [blm_pkg::TICK8_W-1:0]   r_off_counter,     n_off_counter;
    logic [blm_pkg::RECOV_W-1:0]   r_recover_counter, n_recover_counter;
    logic [blm_pkg::FULL_W-1:0]    r_full_counter,    n_full_counter;

    logic [blm_pkg::TICK8_W-1:0]   w_low_inc;
    logic [blm_pkg::TICK8_W-1:0]   w_off_inc;
    logic [blm_pkg::RECOV_W-1:0]   w_recover_inc;
    logic [blm_pkg::FULL_W-1:0]    w_full_inc;
    logic [blm_pkg::EV_W-1:0]      w_event;
    logic [blm_pkg::MV_W-1:0]      w_mv;

    // Saturating increments
    assign w_low_inc     = (r_low_counter == TICK8_MAX) ? r_low_counter
                                                        : r_low_counter + 8'd1;
    assign w_off_inc     = (r_off_counter == TICK8_MAX) ? r_off_counter
                                                        : r_off_counter + 8'd1;
    assign w_recover_inc = (r_recover_counter == RECOV_MAX) ? r_recover_counter
                                                            : r_recover_counter + 5'd1;
    assign w_full_inc    = (r_full_counter == FULL_MAX) ? r_full_counter
                                                        : r_full_counter + 10'd1;
    assign w_mv = i_item.battery_mv;

    // Voltage check, then charger handling
    always_comb begin
        n_low_mode        = r_low_mode;
        n_charging_seen   = r_charging_seen;
        n_full_seen       = r_full_seen;
        n_low_counter     = r_low_counter;
        n_off_counter     = r_off_counter;
        n_recover_counter = r_recover_counter;
        n_full_counter    = r_full_counter;
        w_event           = blm_pkg::EV_NONE;

        if (!r_low_mode) begin
            if (w_mv < i_cfg.low_warn_mv) begin
                n_low_counter = w_low_inc;
                if (w_low_inc > i_cfg.low_detect_ticks) begin
                    n_low_mode    = 1'b1;
                    n_low_counter = '0;
                    w_event       = blm_pkg::EV_LOW_WARN;
                end
            end else begin
                if (r_charging_seen) begin
                    if (!r_full_seen) begin
                        // count toward full charge
                        if (w_mv >= i_cfg.full_mv) begin
                            n_full_counter = w_full_inc;
                            if (w_full_inc >= i_cfg.full_detect_ticks) begin
                                n_full_seen    = 1'b1;
                                n_full_counter = '0;
                                w_event        = blm_pkg::EV_FULL;
                            end
                        end else begin
                            n_full_counter = '0;
                        end
                    end else begin
                        // count toward dropping the full flag
                        if (w_mv < i_cfg.recharge_mv) begin
                            n_full_counter = w_full_inc;
                            if (w_full_inc >= blm_pkg::FULL_DROP_TICKS) begin
                                n_full_seen    = 1'b0;
                                n_full_counter = '0;
                            end
                        end else begin
                            n_full_counter = '0;
                        end
                    end
                end else begin
                    n_full_counter = '0;
                    n_full_seen    = 1'b0;
                end
                n_low_counter = '0;
            end
        end else begin
            if (w_mv < i_cfg.shutdown_mv) begin
                n_recover_counter = '0;
                n_off_counter     = w_off_inc;
                if (w_off_inc > i_cfg.shutdown_ticks) begin
                    n_off_counter = '0;
                    w_event       = blm_pkg::EV_SHUTDOWN;
                end
            end else if (w_mv > i_cfg.low_cancel_mv) begin
                n_off_counter     = '0;
                n_recover_counter = w_recover_inc;
                if (w_recover_inc > blm_pkg::RECOVER_TICKS) begin
                    n_low_mode        = 1'b0;
                    n_recover_counter = '0;
                    w_event           = blm_pkg::EV_LOW_CLEARED;
                end
            end else begin
                // repeat the warning periodically
                n_low_counter = w_low_inc;
                if (w_low_inc > blm_pkg::REPEAT_WARN_TICKS) begin
                    n_low_counter = '0;
                    w_event       = blm_pkg::EV_LOW_WARN;
                end
                n_recover_counter = '0;
                n_off_counter     = '0;
            end
        end

        // Charger insertion drops low mode silently
        if (i_item.charger_on && !r_charging_seen && !n_full_seen) begin
            n_charging_seen   = 1'b1;
            n_low_mode        = 1'b0;
            n_recover_counter = '0;
        end else if (!i_item.charger_on) begin
            n_charging_seen = 1'b0;
        end
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_mode        <= 1'b0;
            r_charging_seen   <= 1'b0;
            r_full_seen       <= 1'b0;
            r_low_counter     <= '0;
            r_off_counter     <= '0;
            r_recover_counter <= '0;
            r_full_counter    <= '0;
        end else if (i_adv) begin
            r_low_mode        <= n_low_mode;
            r_charging_seen   <= n_charging_seen;
            r_full_seen       <= n_full_seen;
            r_low_counter     <= n_low_counter;
            r_off_counter     <= n_off_counter;
            r_recover_counter <= n_recover_counter;
            r_full_counter    <= n_full_counter;
        end
    end

    // Assemble the result
    always_comb begin
        o_result.event_code = w_event;
        if (i_item.charger_on && (i_item.charge_percent < blm_pkg::PCT_FULL)) begin
            o_result.level_report = -8'sd1;
        end else begin
            o_result.level_report = $signed({1'b0, i_item.charge_percent});
        end
        o_result.low_active = n_low_mode;
    end

    // Recovery always leaves low mode
    a_cleared_not_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_event == blm_pkg::EV_LOW_CLEARED) |=> !r_low_mode)
        else $error("low mode still set after recovery event");

    // Full charge is only declared while charging was seen
    a_full_needs_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_event == blm_pkg::EV_FULL) |-> r_charging_seen)
        else $error("full event without charger");

    // Shutdown request only from low mode
    a_shutdown_in_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_event == blm_pkg::EV_SHUTDOWN) |-> r_low_mode)
        else $error("shutdown request outside low mode");

endmodule

### sv/battery_level_monitor.sv
// ----------------------------------------------------------------------------
// battery_level_monitor
// Per-tick battery supervisor: low warning, shutdown request, recovery and
// full-charge detection with debounce counters and a configurable threshold set.
// ----------------------------------------------------------------------------
// Pipeline: an input transfer is held in the input register, then its result
//   is held in the result register.
// Throughput: one item per cycle unless the output stalls; the monitor state
//   updates in a single pass as the item moves from input to result register.
// Reset (synchronous, active low): clears the pipeline valids and monitor
//   state, and loads the default thresholds.
// ----------------------------------------------------------------------------
module battery_level_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    blm_stream_if.sink                    i_in,
    blm_stream_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [blm_pkg::CFG_DAT_W-1:0] i_cfg_wdata
);

    blm_pkg::t_cfg      w_cfg;
    blm_pkg::t_out_item w_result;
    blm_pkg::t_in_item  r_s1_item;
    blm_pkg::t_out_item r_out_data;
    logic               r_s1_valid;
    logic               r_out_valid;
    logic               w_out_free;
    logic               w_adv;
    logic               w_in_xfer;

    blm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    blm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_s1_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Pipeline flow control
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_s1_valid && w_out_free;
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= w_in_xfer || (r_s1_valid && !w_adv);
            r_out_valid <= w_adv || (r_out_valid && !o_out.ready);
        end
    end

    // Hold payloads
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_item <= i_in.data;
        end
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // An item that advances always lands in the result register
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced item lost");

    // A stalled input stage blocks new transfers
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |-> !i_in.ready)
        else $error("input accepted over a stalled item");

    // Event codes stay within the defined set
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.event_code <= blm_pkg::EV_LOW_CLEARED))
        else $error("undefined event code");

endmodule
